// ----- sv/indexed_insert_delete_list_defines.svh -----
// Assertion macros used by the indexed list top level.
`ifndef INDEXED_INSERT_DELETE_LIST_DEFINES_SVH
`define INDEXED_INSERT_DELETE_LIST_DEFINES_SVH

// Checked only while the block is out of reset.
`define IIL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define IIL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/iil_pkg.sv -----
// Shared types and constants of the indexed list.
package iil_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int OP_WIDTH   = 3;
    localparam int POS_WIDTH  = 5;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_FIND   = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    // Update command broadcast to every cell of the row.
    typedef struct packed {
        logic                  ins;
        logic                  del;
        logic                  set;
        logic [ELEM_WIDTH-1:0] value;
    } t_cell_ctrl;

endpackage

// ----- sv/indexed_insert_delete_list.sv -----
// Indexed list top level: request decode, row of storage cells and result register.
// An accepted request stays pending until the result register is free or is being
// taken; its result is then registered. No request is accepted while one is pending.
// The row updates and registers its compare flags when a request is accepted, and
// the find priority encode and read-back OR run when the pending result resolves.
// Reset clears the element count and the handshake state; entry contents stay
// undefined until written, which is never observed since only held entries are read.
module indexed_insert_delete_list #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] operation, [7:3] position, [39:8] value
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] ok, [32:1] read_value, [36:33] found_position, [41:37] length,
    // [42] empty_res, [47:43] zero
    output logic [47:0] m_axis_tdata
);
    import iil_pkg::*;

    `include "indexed_insert_delete_list_defines.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int MW = (CW > POS_WIDTH) ? CW : POS_WIDTH;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Request fields
    t_op                   w_op;
    logic [POS_WIDTH-1:0]  w_pos;
    logic [ELEM_WIDTH-1:0] w_value;
    logic [MW-1:0]         w_pos_m;
    logic [MW-1:0]         w_cnt_m;
    logic                  w_accept;
    logic                  w_in_range;
    logic                  w_ins_ok;
    logic                  w_ok_pre;
    t_cell_ctrl            w_ctrl;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_pend;
    t_op                   r_op;
    logic                  r_ok_pre;

    logic [ELEM_WIDTH-1:0] w_data [CAPACITY];
    logic [ELEM_WIDTH-1:0] w_hit  [CAPACITY];
    logic [CAPACITY-1:0]   w_match;
    logic [CAPACITY-1:0]   w_lowest;
    logic [ELEM_WIDTH-1:0] w_rd_or;
    logic [IW-1:0]         w_fp;
    logic                  w_any;

    logic                  r_out_valid;
    logic                  r_ok;
    logic [ELEM_WIDTH-1:0] r_rd;
    logic [3:0]            r_fp;
    logic [4:0]            r_len;
    logic                  r_empty;
    logic                  w_resolve;

    assign w_op    = t_op'(s_axis_tdata[2:0]);
    assign w_pos   = s_axis_tdata[7:3];
    assign w_value = s_axis_tdata[39:8];
    assign w_pos_m = MW'(w_pos);
    assign w_cnt_m = MW'(r_count);

    assign s_axis_tready = !r_pend && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_in_range = w_pos_m < w_cnt_m;
    assign w_ins_ok   = (w_pos_m <= w_cnt_m) && (r_count < CAP_CNT);

    always_comb begin
        w_ok_pre = 1'b0;
        n_count  = r_count;
        case (w_op)
            OP_GET: begin
                w_ok_pre = w_in_range;
            end
            OP_SET: begin
                w_ok_pre = w_in_range;
            end
            OP_INSERT: begin
                w_ok_pre = w_ins_ok;
                if (w_ins_ok) begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_DELETE: begin
                w_ok_pre = w_in_range;
                if (w_in_range) begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_CLEAR: begin
                w_ok_pre = 1'b1;
                n_count  = '0;
            end
            default: begin
                w_ok_pre = 1'b0;
            end
        endcase
    end

    assign w_ctrl.ins   = (w_op == OP_INSERT) && w_ins_ok;
    assign w_ctrl.del   = (w_op == OP_DELETE) && w_in_range;
    assign w_ctrl.set   = (w_op == OP_SET) && w_in_range;
    assign w_ctrl.value = w_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEM_WIDTH-1:0] w_left;
        logic [ELEM_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_data[g-1];
        end

        // The last cell refills itself on a delete; that slot is no longer held.
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner_r
            assign w_right = w_data[g+1];
        end

        iil_cell #(
            .IDX (g),
            .PW  (MW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_load  (w_accept),
            .i_ctrl  (w_ctrl),
            .i_pos   (w_pos_m),
            .i_count (w_cnt_m),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_match (w_match[g]),
            .o_hit   (w_hit[g])
        );
    end

    // Isolate the lowest matching cell with a two's complement trick.
    assign w_lowest = w_match & (~w_match + 1'b1);
    assign w_any    = |w_match;

    always_comb begin
        w_rd_or = '0;
        w_fp    = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_or = w_rd_or | w_hit[i];
            if (w_lowest[i]) begin
                w_fp = w_fp | IW'(i);
            end
        end
    end

    assign w_resolve = r_pend && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_pend  <= 1'b1;
            end
            if (w_resolve) begin
                r_pend      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= w_op;
            r_ok_pre <= w_ok_pre;
        end
        if (w_resolve) begin
            r_ok    <= (r_op == OP_FIND) ? w_any : r_ok_pre;
            r_rd    <= ((r_op == OP_GET || r_op == OP_DELETE) && r_ok_pre) ? w_rd_or : '0;
            r_fp    <= ((r_op == OP_FIND) && w_any) ? 4'(w_fp) : 4'd0;
            r_len   <= 5'(r_count);
            r_empty <= (r_count == '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_empty, r_len, r_fp, r_rd, r_ok};

    `IIL_ASSERT(a_no_accept_while_pending, r_pend |-> !s_axis_tready, "request accepted while one is pending")
    `IIL_ASSERT(a_accept_sets_pending, w_accept |=> r_pend, "accepted request not pending")
    `IIL_ASSERT(a_count_bounded, r_count <= CAP_CNT, "element count above capacity")
    `IIL_ASSERT(a_empty_matches_length, r_out_valid |-> (r_empty == (r_len == 5'd0)), "empty flag disagrees with length")
    `IIL_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!r_pend && !r_out_valid), "handshake state not cleared by reset")

endmodule

// ----- sv/iil_cell.sv -----
// One storage cell of the list row: holds one entry, shifts with its neighbors.
module iil_cell #(
    parameter int IDX = 0,
    parameter int PW  = 5
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  iil_pkg::t_cell_ctrl           i_ctrl,
    input  logic [PW-1:0]                 i_pos,
    input  logic [PW-1:0]                 i_count,
    input  logic [iil_pkg::ELEM_WIDTH-1:0] i_left,
    input  logic [iil_pkg::ELEM_WIDTH-1:0] i_right,
    output logic [iil_pkg::ELEM_WIDTH-1:0] o_data,
    output logic                          o_match,
    output logic [iil_pkg::ELEM_WIDTH-1:0] o_hit
);
    import iil_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [ELEM_WIDTH-1:0] r_data;
    logic [ELEM_WIDTH-1:0] n_data;
    logic                  r_match;
    logic [ELEM_WIDTH-1:0] r_hit;

    always_comb begin
        n_data = r_data;
        if (i_load) begin
            if (i_ctrl.ins) begin
                if (MY_IDX > i_pos) begin
                    n_data = i_left;
                end else if (MY_IDX == i_pos) begin
                    n_data = i_ctrl.value;
                end
            end else if (i_ctrl.del && (MY_IDX >= i_pos)) begin
                n_data = i_right;
            end else if (i_ctrl.set && (MY_IDX == i_pos)) begin
                n_data = i_ctrl.value;
            end
        end
    end

    // Compare and select flags are taken from the contents before the update.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_load) begin
            r_match <= (MY_IDX < i_count) && (r_data == i_ctrl.value);
            r_hit   <= (MY_IDX == i_pos) ? r_data : '0;
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;
    assign o_hit   = r_hit;

endmodule

// ----- sim/indexed_insert_delete_list_tb.sv -----
// Self-checking stream testbench for the indexed insert/delete list.
`timescale 1ns / 1ps

module indexed_insert_delete_list_tb;
    import iil_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int STUCK_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int CALM_TAIL   = 150;

    // Operation codes outside the package enum; the block must refuse them.
    localparam logic [OP_WIDTH-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [OP_WIDTH-1:0] OP_RSVD_HI = 3'd7;

    // Random segment flavors that steer the list length.
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED  = 2;

    typedef struct packed {
        logic [ELEM_WIDTH-1:0] value;
        logic [POS_WIDTH-1:0]  position;
        logic [OP_WIDTH-1:0]   op;
    } t_list_req;

    typedef struct packed {
        logic [4:0]            pad;
        logic                  empty;
        logic [4:0]            len;
        logic [3:0]            found;
        logic [ELEM_WIDTH-1:0] rdata;
        logic                  ok;
    } t_list_result;

    typedef struct {
        t_list_req req;
        bit        drain;
    } t_pending_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [2:0] operation, [7:3] position, [39:8] value
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] ok, [32:1] read_value, [36:33] found_position, [41:37] length,
    // [42] empty_res, [47:43] zero
    logic [47:0] m_axis_tdata;

    t_pending_req    req_queue[$];
    t_list_result    results_due[$];
    logic [ELEM_WIDTH-1:0] list_mem[LIST_DEPTH];
    int              list_len = 0;
    int              errors = 0;
    int              result_idx = 0;
    int              stuck_cycles = 0;
    int              idle_left = 0;
    int              stall_left = 0;
    bit              in_took = 1'b0;
    bit              calm = 1'b0;

    indexed_insert_delete_list #(.CAPACITY(LIST_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Applies one request to the shadow list and returns the result it must produce.
    function automatic t_list_result apply_list_op(t_list_req r);
        t_list_result res;
        int k;
        res = '0;
        case (r.op)
            OP_GET: begin
                if (r.position < list_len) begin
                    res.rdata = list_mem[r.position];
                    res.ok = 1'b1;
                end
            end
            OP_SET: begin
                if (r.position < list_len) begin
                    list_mem[r.position] = r.value;
                    res.ok = 1'b1;
                end
            end
            OP_INSERT: begin
                if (r.position <= list_len && list_len < LIST_DEPTH) begin
                    for (k = list_len; k > r.position; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[r.position] = r.value;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            OP_DELETE: begin
                if (r.position < list_len) begin
                    res.rdata = list_mem[r.position];
                    for (k = r.position; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            OP_FIND: begin
                for (k = 0; k < list_len; k++) begin
                    if (!res.ok && list_mem[k] == r.value) begin
                        res.found = k[3:0];
                        res.ok = 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                list_len = 0;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.len = list_len[4:0];
        res.empty = (list_len == 0);
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
        $display("ERROR: result %0d field %s: got 0x%0h, expected 0x%0h",
                 result_idx, field, got, want);
        errors++;
    endtask

    task automatic queue_req(logic [2:0] op, int pos, logic [31:0] val, bit drain = 1'b0);
        t_pending_req p;
        p.req.op = op;
        p.req.position = pos[POS_WIDTH-1:0];
        p.req.value = val;
        p.drain = drain;
        req_queue.push_back(p);
    endtask

    // Request side: one transaction per handshake, occasional idle bursts between items.
    always @(negedge i_clk) begin
        t_pending_req p;
        if (i_rst_n) begin
            if (req_queue.size() < CALM_TAIL)
                calm = 1'b1;
            if (s_axis_tvalid && !in_took) begin
                // Hold the current transaction until it is taken.
            end else if (idle_left > 0) begin
                in_took = 1'b0;
                idle_left--;
                s_axis_tvalid <= 1'b0;
            end else if (req_queue.size() == 0 ||
                         (req_queue[0].drain && results_due.size() != 0)) begin
                in_took = 1'b0;
                s_axis_tvalid <= 1'b0;
            end else begin
                in_took = 1'b0;
                p = req_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= p.req;
                if (!calm && $urandom_range(0, 99) < 9)
                    idle_left = $urandom_range(1, 14);
            end
        end
    end

    // Result side back-pressure.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (i_rst_n && !calm && $urandom_range(0, 99) < 7)
                stall_left = $urandom_range(1, 14);
        end
    end

    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                results_due.push_back(apply_list_op(t_list_req'(s_axis_tdata)));
                in_took = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_list_result'(m_axis_tdata);
                if (results_due.size() == 0) begin
                    $display("ERROR: result %0d arrived with no request outstanding",
                             result_idx);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (got.ok !== want.ok)
                        report_mismatch("ok", got.ok, want.ok);
                    if (got.rdata !== want.rdata)
                        report_mismatch("read_value", got.rdata, want.rdata);
                    if (got.found !== want.found)
                        report_mismatch("found_position", got.found, want.found);
                    if (got.len !== want.len)
                        report_mismatch("length", got.len, want.len);
                    if (got.empty !== want.empty)
                        report_mismatch("empty_res", got.empty, want.empty);
                    if (got.pad !== want.pad)
                        report_mismatch("padding", got.pad, want.pad);
                end
                result_idx++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("indexed_insert_delete_list_tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] pool[8];
        logic [31:0] val;
        logic [2:0]  op;
        int          gen_len;
        int          n_rand;
        int          mode;
        int          seg;
        int          r;
        int          pos;
        int          p_ins;
        int          p_del;
        int          i;

        // Directed part: empty list, ends, middle, misses and refused codes.
        queue_req(OP_RSVD_LO, 0, 32'h0);
        queue_req(OP_RSVD_HI, 31, 32'hFFFF_FFFF);
        queue_req(OP_GET, 0, 32'h0);
        queue_req(OP_FIND, 0, 32'h0);
        queue_req(OP_DELETE, 0, 32'h0);
        queue_req(OP_SET, 0, 32'h1);
        queue_req(OP_INSERT, 1, 32'h1);
        queue_req(OP_INSERT, 0, 32'h0);
        queue_req(OP_INSERT, 1, 32'hFFFF_FFFF);
        queue_req(OP_INSERT, 0, 32'h5A5A_A5A5);
        queue_req(OP_INSERT, 1, 32'h0000_0001);
        queue_req(OP_GET, 3, 32'h0);
        queue_req(OP_GET, 4, 32'h0);
        queue_req(OP_SET, 2, 32'h8000_0000);
        queue_req(OP_FIND, 0, 32'hFFFF_FFFF);
        queue_req(OP_FIND, 0, 32'h0000_1234);
        queue_req(OP_DELETE, 0, 32'h0);
        queue_req(OP_DELETE, 2, 32'h0);
        queue_req(OP_GET, 31, 32'h0);
        queue_req(OP_SET, 16, 32'hDEAD_BEEF);
        queue_req(OP_INSERT, 31, 32'hCAFE_F00D);
        queue_req(OP_CLEAR, 0, 32'h0);
        queue_req(OP_CLEAR, 0, 32'h0);
        queue_req(OP_GET, 0, 32'h0);
        gen_len = 0;

        // Finds only hit often when values repeat, so half the values come from a pool.
        pool[0] = 32'h0;
        pool[1] = 32'hFFFF_FFFF;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'h1;
        for (i = 4; i < 8; i++)
            pool[i] = $urandom;

        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            mode = $urandom_range(MODE_GROW, MODE_MIXED);
            seg = $urandom_range(10, 60);
            p_ins = (mode == MODE_GROW) ? 60 : (mode == MODE_SHRINK) ? 15 : 30;
            p_del = (mode == MODE_GROW) ? 10 : (mode == MODE_SHRINK) ? 50 : 25;
            for (i = 0; i < seg; i++) begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    op = $urandom_range(0, 1) ? OP_RSVD_LO : OP_RSVD_HI;
                else if (r < 3 && mode != MODE_GROW)
                    op = OP_CLEAR;
                else if (r < 3 + p_ins)
                    op = OP_INSERT;
                else if (r < 3 + p_ins + p_del)
                    op = OP_DELETE;
                else begin
                    case ($urandom_range(0, 2))
                        0: op = OP_GET;
                        1: op = OP_SET;
                        default: op = OP_FIND;
                    endcase
                end
                if ($urandom_range(0, 99) < 85)
                    pos = $urandom_range(0, gen_len);
                else
                    pos = $urandom_range(0, 31);
                val = $urandom_range(0, 1) ? pool[$urandom_range(0, 7)] : $urandom;
                // The first random item always waits for the pipeline to empty.
                queue_req(op, pos, val, n_rand == 0 || (i == 0 && $urandom_range(0, 6) == 0));
                if (op == OP_INSERT && pos <= gen_len && gen_len < LIST_DEPTH)
                    gen_len++;
                else if (op == OP_DELETE && pos < gen_len)
                    gen_len--;
                else if (op == OP_CLEAR)
                    gen_len = 0;
                n_rand++;
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (req_queue.size() != 0 || s_axis_tvalid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (results_due.size() != 0) begin
            $display("ERROR: %0d expected results never arrived", results_due.size());
            errors++;
        end
        if (errors == 0)
            $display("indexed_insert_delete_list_tb: PASS");
        else
            $display("indexed_insert_delete_list_tb: FAIL");
        $finish;
    end

endmodule
